>>> src/pwc_pkg.sv
// Shared types and constants of the payload HTTP/binary classifier.
// Used by pwc_cell, pwc_judge and the top level; no dependencies of its own.
package pwc_pkg;

	localparam int PREFIX_LENGTH = 24;

	// Configuration register indexes.
	localparam logic [1:0] REG_PERCENT    = 2'd0;
	localparam logic [1:0] REG_FRAME_TYP  = 2'd1;
	localparam logic [1:0] REG_FRAME_SIZE = 2'd2;

	localparam logic [6:0]  PERCENT_RST    = 7'd50;
	localparam logic [7:0]  FRAME_TYP_RST  = 8'd9;
	localparam logic [23:0] FRAME_SIZE_RST = 24'd65536;

	// Verdict reason codes.
	localparam logic [2:0] RSN_SHORT    = 3'd0;
	localparam logic [2:0] RSN_REQUEST  = 3'd1;
	localparam logic [2:0] RSN_RESPONSE = 3'd2;
	localparam logic [2:0] RSN_PREFACE  = 3'd3;
	localparam logic [2:0] RSN_FRAME    = 3'd4;
	localparam logic [2:0] RSN_BINARY   = 3'd5;
	localparam logic [2:0] RSN_TEXT     = 3'd6;

	// Bytes below this value count as control bytes, except tab, LF and CR.
	localparam logic [7:0] CTRL_LIMIT = 8'h20;
	localparam logic [7:0] CHR_TAB    = 8'h09;
	localparam logic [7:0] CHR_LF     = 8'h0a;
	localparam logic [7:0] CHR_CR     = 8'h0d;

	// Four-byte tags, first payload byte in the top bits.
	localparam int METHOD_COUNT = 7;
	localparam logic [31:0] METHOD_TAG [METHOD_COUNT] = '{
		"GET ", "POST", "PUT ", "HEAD", "DELE", "PATC", "OPTI"
	};
	localparam logic [31:0] HTTP_TAG = "HTTP";
	localparam logic [31:0] PRI_TAG  = "PRI ";

	// HTTP/2 connection preface, byte 0 in the top bits.
	localparam logic [8*PREFIX_LENGTH-1:0] PREFACE = {
		"PRI * HTTP/2.0", CHR_CR, CHR_LF, CHR_CR, CHR_LF,
		"SM", CHR_CR, CHR_LF, CHR_CR, CHR_LF
	};

	typedef struct packed {
		logic [6:0]  percent;
		logic [7:0]  frame_typ;
		logic [23:0] frame_size;
	} cfg_t;

	// Control that every prefix cell sees.
	typedef struct packed {
		logic load;     // a word is accepted this cycle
		logic restart;  // the next word is byte 0 of a payload
		logic clear;    // drop the token without a new word
	} cell_ctl_t;

endpackage

>>> src/pwc_cell.sv
// One prefix cell: holds one payload byte and passes the position token on.
// Depends on pwc_pkg.
module pwc_cell
	import pwc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  logic       head,
	input  logic       tok_in,
	input  logic [7:0] din,
	input  logic [7:0] expect_byte,
	output logic       tok_cur,
	output logic [7:0] data_q,
	output logic       match_q
);

	logic tok_q;

	// On a fresh payload only the head cell owns the token.
	assign tok_cur = ctl.restart ? head : tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctl.load) begin
			tok_q <= tok_in;
		end else if (ctl.clear) begin
			tok_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && tok_cur) begin
			data_q  <= din;
			match_q <= (din == expect_byte);
		end
	end

endmodule

>>> src/pwc_judge.sv
// Two-stage verdict pipeline with output register and stream handshake.
// Depends on pwc_pkg; fed with a snapshot of the prefix cells and counters.
module pwc_judge
	import pwc_pkg::*;
#(
	parameter int SCAN_WINDOW = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 pend,
	input  logic [31:0]          head_word,
	input  logic                 pref_ok,
	input  logic [$clog2(SCAN_WINDOW+PREFIX_LENGTH+1)-1:0] pos,
	input  logic [$clog2(SCAN_WINDOW+1)-1:0]               cnt,
	output logic                 free,
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output logic [7:0]           m_tdata
);

	localparam int PW  = $clog2(SCAN_WINDOW + PREFIX_LENGTH + 1);
	localparam int CW  = $clog2(SCAN_WINDOW + 1);
	localparam int PRW = CW + 8;

	logic           v_s1;
	logic           ge2_s1, req_s1, resp_s1, pri_s1, frame_s1;
	logic [PRW-1:0] prod_cnt_s1, prod_thr_s1;
	logic [2:0]     reason_q;
	logic           out_v_q;

	logic           out_ready, load;
	logic           ge4, ge9, ge24, req_hit;
	logic [CW-1:0]  win;
	logic [2:0]     reason_nxt;

	assign out_ready = !out_v_q || m_tready;
	assign free      = !v_s1 || out_ready;
	assign load      = pend && free;

	always_comb begin
		req_hit = 1'b0;
		for (int i = 0; i < METHOD_COUNT; i++) begin
			req_hit = req_hit | (head_word == METHOD_TAG[i]);
		end
	end

	assign ge4  = pos >= PW'(4);
	assign ge9  = pos >= PW'(9);
	assign ge24 = pos >= PW'(PREFIX_LENGTH);
	assign win  = (pos > PW'(SCAN_WINDOW)) ? CW'(SCAN_WINDOW) : CW'(pos);

	// Stage 1: tag compares, frame header check and the two products.
	always_ff @(posedge clk) begin
		if (load) begin
			ge2_s1      <= pos >= PW'(2);
			req_s1      <= ge4 && req_hit;
			resp_s1     <= ge4 && (head_word == HTTP_TAG);
			pri_s1      <= (ge24 && pref_ok) || (ge4 && (head_word == PRI_TAG));
			frame_s1    <= ge9 && (head_word[7:0] <= cfg.frame_typ)
			               && (head_word[31:8] <= cfg.frame_size);
			prod_cnt_s1 <= PRW'(cnt) * PRW'(100);
			prod_thr_s1 <= (PRW'(cfg.percent) + PRW'(1)) * PRW'(win);
		end
	end

	// Stage 2: rule priority.
	always_comb begin
		if (!ge2_s1) begin
			reason_nxt = RSN_SHORT;
		end else if (req_s1) begin
			reason_nxt = RSN_REQUEST;
		end else if (resp_s1) begin
			reason_nxt = RSN_RESPONSE;
		end else if (pri_s1) begin
			reason_nxt = RSN_PREFACE;
		end else if (frame_s1) begin
			reason_nxt = RSN_FRAME;
		end else if (prod_cnt_s1 >= prod_thr_s1) begin
			reason_nxt = RSN_BINARY;
		end else begin
			reason_nxt = RSN_TEXT;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && out_ready) begin
			reason_q <= reason_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				v_s1 <= 1'b1;
			end else if (out_ready) begin
				v_s1 <= 1'b0;
			end
			if (out_ready) begin
				out_v_q <= v_s1;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'd0, reason_q,
	                   (reason_q == RSN_SHORT) || (reason_q == RSN_BINARY)};

endmodule

>>> src/payload_http_vs_binary_classifier.sv
// Top level of the payload classifier: HTTP-like text versus binary/IPC.
// Depends on pwc_pkg, pwc_cell and pwc_judge.
//
//  channel | dir | width      | contents
//  --------+-----+------------+-------------------------------------------
//  s_*     | in  | 8 + tlast  | one payload byte per word, tlast on the last
//  m_*     | out | 8          | one verdict word per payload
//  cfg_*   | in  | 2 + 24     | register writes, no read-back
//
// The block takes one payload byte in every cycle, without gaps between
// payloads, unless the input is held as described below. After the last
// byte, the prefix cells are snapshot into the compare/multiply stage, and
// the rule priority then goes into the output register. The two products of the
// control-byte test are the deepest logic and set the clock, not the rate.
// Reset clears the counters, the position token and the pipeline valids.
// A stalled output holds the input only when a finished payload is waiting
// and the verdict stage is full.
module payload_http_vs_binary_classifier
	import pwc_pkg::*;
#(
	parameter int SCAN_WINDOW = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] payload_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] is_binary, [3:1] verdict_reason, [7:4] zero
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [23:0] cfg_data
);

	localparam int PW       = $clog2(SCAN_WINDOW + PREFIX_LENGTH + 1);
	localparam int CW       = $clog2(SCAN_WINDOW + 1);
	localparam int POS_SAT  = SCAN_WINDOW + PREFIX_LENGTH;

	cfg_t          cfg_q;
	logic [PW-1:0] pos_q;
	logic [CW-1:0] cnt_q;
	logic          pend_q;

	logic          accept, free, restart, is_ctrl;
	logic [PW-1:0] base_pos;
	logic [CW-1:0] base_cnt;
	cell_ctl_t     ctl;

	logic [PREFIX_LENGTH:0]   tok_chain;
	logic [7:0]               cell_byte  [PREFIX_LENGTH];
	logic [PREFIX_LENGTH-1:0] cell_match;

	// Configuration registers; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.percent    <= PERCENT_RST;
			cfg_q.frame_typ  <= FRAME_TYP_RST;
			cfg_q.frame_size <= FRAME_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_PERCENT:    cfg_q.percent    <= cfg_data[6:0];
				REG_FRAME_TYP:  cfg_q.frame_typ  <= cfg_data[7:0];
				REG_FRAME_SIZE: cfg_q.frame_size <= cfg_data;
				default: ;
			endcase
		end
	end

	// A finished payload waits in the cells (pend_q) until the verdict stage
	// takes its snapshot; a new word may enter in that same cycle.
	assign s_tready = !pend_q || free;
	assign accept   = s_tvalid && s_tready;
	assign restart  = pend_q || (pos_q == '0);
	assign base_pos = pend_q ? '0 : pos_q;
	assign base_cnt = pend_q ? '0 : cnt_q;

	assign is_ctrl = (s_tdata < CTRL_LIMIT) && (s_tdata != CHR_TAB)
	                 && (s_tdata != CHR_LF) && (s_tdata != CHR_CR);

	assign ctl.load    = accept;
	assign ctl.restart = restart;
	assign ctl.clear   = pend_q && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cnt_q  <= '0;
			pend_q <= 1'b0;
		end else if (accept) begin
			// The position saturates; every length test stays below the limit.
			if (base_pos < PW'(POS_SAT)) begin
				pos_q <= base_pos + PW'(1);
			end else begin
				pos_q <= base_pos;
			end
			if ((base_pos < PW'(SCAN_WINDOW)) && is_ctrl) begin
				cnt_q <= base_cnt + CW'(1);
			end else begin
				cnt_q <= base_cnt;
			end
			pend_q <= s_tlast;
		end else if (pend_q && free) begin
			pos_q  <= '0;
			cnt_q  <= '0;
			pend_q <= 1'b0;
		end
	end

	// Row of prefix cells; the token marks the cell that takes the next byte.
	assign tok_chain[0] = 1'b0;

	for (genvar i = 0; i < PREFIX_LENGTH; i++) begin : g_cell
		pwc_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.head        (i == 0),
			.tok_in      (tok_chain[i]),
			.din         (s_tdata),
			.expect_byte (PREFACE[8*(PREFIX_LENGTH-i)-1 -: 8]),
			.tok_cur     (tok_chain[i+1]),
			.data_q      (cell_byte[i]),
			.match_q     (cell_match[i])
		);
	end

	pwc_judge #(
		.SCAN_WINDOW (SCAN_WINDOW)
	) u_judge (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pend      (pend_q),
		.head_word ({cell_byte[0], cell_byte[1], cell_byte[2], cell_byte[3]}),
		.pref_ok   (&cell_match),
		.pos       (pos_q),
		.cnt       (cnt_q),
		.free      (free),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule
